/* rtl/core/mint_pkg.sv */
// shared types and constants for the mac/ip neighbor table
package mint_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] AGE_TIMEOUT_RESET = 16'd5;

	typedef enum logic {
		ACT_ADD    = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [47:0] mac_addr;
		logic        is_ipv4;
		logic [63:0] ip_high;
		logic [63:0] ip_low;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [47:0] mac_out;
		logic [3:0]  entry_index;
	} rsp_t;

	// classified command handed from the front part to the back part
	typedef struct packed {
		action_t     act;
		logic [47:0] mac;
		logic        v4;
		logic [63:0] ip_hi;
		logic [63:0] ip_lo;
		logic [31:0] now;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;
endpackage

/* rtl/core/mint_front.sv */
// front part: accepts items, normalizes ipv4 fields and queues commands
module mint_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  mint_pkg::req_t in_data,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output mint_pkg::cmd_t cmd_data
);
	import mint_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	cmd_t            cls;
	logic            push;
	logic            pop;

	// classify: ipv4 keeps low 32 bits, upper half zero
	always_comb begin
		cls.act   = action_t'(in_data.action);
		cls.mac   = in_data.mac_addr;
		cls.v4    = in_data.is_ipv4;
		cls.ip_hi = in_data.is_ipv4 ? 64'd0 : in_data.ip_high;
		cls.ip_lo = in_data.is_ipv4 ? {32'd0, in_data.ip_low[31:0]} : in_data.ip_low;
		cls.now   = in_data.now_seconds;
	end

	assign in_stall  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd_data  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance");
endmodule

/* rtl/core/mint_back.sv */
// back part: scans the table one entry per cycle and updates it
module mint_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_take,
	input  mint_pkg::cmd_t cmd_data,
	input  logic [15:0]    age_timeout,
	output logic           out_valid,
	input  logic           out_stall,
	output mint_pkg::rsp_t out_data
);
	import mint_pkg::*;

	// table storage
	logic [47:0] tab_mac_q   [TABLE_DEPTH];
	logic        tab_v4_q    [TABLE_DEPTH];
	logic [63:0] tab_hi_q    [TABLE_DEPTH];
	logic [63:0] tab_lo_q    [TABLE_DEPTH];
	logic [31:0] tab_stamp_q [TABLE_DEPTH];

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;
	logic             found_q;
	logic [IDX_W-1:0] hit_q;
	logic             have_old_q;
	logic [IDX_W-1:0] old_q;
	logic [31:0]      old_age_q;
	logic             out_valid_q;
	rsp_t             res_q;
	rsp_t             out_q;

	logic [IDX_W-1:0] si;
	logic             scan_end;
	logic             match;
	logic [31:0]      age;
	logic             do_write;
	logic [IDX_W-1:0] wr_idx;
	logic             grow;

	assign si       = scan_q[IDX_W-1:0];
	assign scan_end = (scan_q >= fill_q) || found_q;
	assign age      = cmd_q.now - tab_stamp_q[si];

	// match of the entry under scan
	always_comb begin
		if (cmd_q.act == ACT_LOOKUP) begin
			match = (tab_v4_q[si] == cmd_q.v4) && (tab_lo_q[si] == cmd_q.ip_lo)
				&& (tab_hi_q[si] == cmd_q.ip_hi);
		end else begin
			match = (tab_mac_q[si] == cmd_q.mac);
		end
	end

	// add target resolution after scan
	always_comb begin
		grow     = 1'b0;
		do_write = 1'b0;
		wr_idx   = hit_q;
		if (found_q) begin
			do_write = 1'b1;
		end else if (fill_q < CNT_W'(TABLE_DEPTH)) begin
			grow     = 1'b1;
			do_write = 1'b1;
			wr_idx   = fill_q[IDX_W-1:0];
		end else if (have_old_q && (old_age_q > {16'd0, age_timeout})) begin
			do_write = 1'b1;
			wr_idx   = old_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = (cmd_q.act == ACT_ADD) ? ST_WRITE : ST_DONE;
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_take = 1'b0;
		case (state_q)
			ST_IDLE: cmd_take = cmd_valid;
			default: cmd_take = 1'b0;
		endcase
	end

	// sequencer state, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_WRITE && grow) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q      <= cmd_data;
				scan_q     <= '0;
				found_q    <= 1'b0;
				hit_q      <= '0;
				have_old_q <= 1'b0;
				old_q      <= '0;
				old_age_q  <= '0;
				res_q      <= '0;
			end
			ST_SCAN: begin
				if (!scan_end) begin
					scan_q <= scan_q + 1'b1;
					if (match) begin
						found_q <= 1'b1;
						hit_q   <= si;
					end else if (!have_old_q || age > old_age_q) begin
						have_old_q <= 1'b1;
						old_q      <= si;
						old_age_q  <= age;
					end
				end else if (cmd_q.act == ACT_LOOKUP && found_q) begin
					res_q.ok          <= 1'b1;
					res_q.mac_out     <= tab_mac_q[hit_q];
					res_q.entry_index <= 4'(hit_q);
				end
			end
			ST_WRITE: begin
				if (do_write) begin
					tab_mac_q[wr_idx]   <= cmd_q.mac;
					tab_v4_q[wr_idx]    <= cmd_q.v4;
					tab_hi_q[wr_idx]    <= cmd_q.ip_hi;
					tab_lo_q[wr_idx]    <= cmd_q.ip_lo;
					tab_stamp_q[wr_idx] <= cmd_q.now;
					res_q.ok            <= 1'b1;
					res_q.entry_index   <= 4'(wr_idx);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count past table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= fill_q))
		else $error("scan past fill count");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> (state_q == ST_IDLE && cmd_valid))
		else $error("command taken while busy");
endmodule

/* rtl/core/mac_ip_neighbor_table.sv */
// top level of the mac/ip neighbor table
// the back part takes a new item only when it has finished the last, including its one-entry-per-cycle table scan
// a two-entry command queue lets items be accepted while the scan runs
// reset: asynchronous active low; clears fill count, queue and state, timeout returns to 5
module mac_ip_neighbor_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  mint_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output mint_pkg::rsp_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);
	import mint_pkg::*;

	logic        cmd_valid;
	logic        cmd_take;
	cmd_t        cmd_data;
	logic [15:0] age_timeout_q;

	assign cfg_ready = 1'b1;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_timeout_q <= AGE_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			age_timeout_q <= cfg_data;
		end
	end

	mint_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd_data  (cmd_data)
	);

	mint_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take),
		.cmd_data    (cmd_data),
		.age_timeout (age_timeout_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);
endmodule
